/* hw/rtl/bitap_pkg.sv */
// ----------------------------------------------------------------------------
// Bitap matcher package
// Shared types and constants for the approximate text matcher and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package bitap_pkg;

  // Pattern geometry.
  localparam int MAX_PATTERN = 7;
  localparam int CHAR_W      = 7;
  localparam int LEN_W       = 3;
  localparam int CHARS_W     = MAX_PATTERN * CHAR_W;
  localparam int ROW_W       = 9;

  // Pattern lengths at or above this allow one error.
  localparam logic [LEN_W-1:0] ERR_DIVISOR = LEN_W'(5);

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = CHARS_W;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_CHARS  = CFG_IDX_W'(1);

  // One text byte with its framing flags.
  typedef struct packed {
    logic [7:0] text_char;
    logic       first_of_text;
    logic       last_of_text;
  } in_data_t;

  // One result per text byte.
  typedef struct packed {
    logic match_found;
    logic search_done;
  } out_data_t;

endpackage

`default_nettype wire

/* hw/rtl/bitap_fuzzy_text_matcher_top.sv */
// Results are registered in the output register or skid entry. Throughput: one
// text byte per cycle unless the skid entry is full; the row update for one
// byte is a single pass of compare and shift-or logic feeding the row
// registers directly. A two-entry output buffer lets one more byte in while a
// result is stalled. Reset is synchronous, active low: rows go to one, the
// found flag and the pattern registers clear, and both buffer entries empty.
// ----------------------------------------------------------------------------
// Bitap fuzzy text matcher
// Matches a byte stream against a short pattern allowing up to one error.
// ----------------------------------------------------------------------------
`default_nettype none

module bitap_fuzzy_text_matcher_top
  import bitap_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Text input
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_data_t              in_data,
  // Results
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_data_t                  out_data,
  // Configuration writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers.
  logic [LEN_W-1:0]   pattern_length_r;
  logic [CHARS_W-1:0] pattern_chars_r;

  // Search state.
  logic [ROW_W-1:0] row0_r, row0_nxt;
  logic [ROW_W-1:0] row1_r, row1_nxt;
  logic             found_r, found_nxt;

  // Output buffer.
  logic      out_valid_r, skid_valid_r;
  out_data_t out_data_r, skid_data_r;
  out_data_t result_nxt;

  logic in_fire, out_fire;

  // Combinational terms of the row update.
  logic [ROW_W-1:0]       base_row0, base_row1;
  logic                   base_found;
  logic                   pat_ok;
  logic                   one_err;
  logic [MAX_PATTERN-1:0] match_mask;
  logic [ROW_W-1:0]       pm_row;
  logic [ROW_W-1:0]       hit0, hit1;
  logic [ROW_W-1:0]       upd_row0, upd_row1;
  logic [ROW_W-1:0]       last_row;

  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid_r && out_ready;
  assign in_ready  = !skid_valid_r;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration writes; indexes beyond the register list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_length_r <= '0;
      pattern_chars_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PATTERN_LENGTH: pattern_length_r <= cfg_data[LEN_W-1:0];
        REG_PATTERN_CHARS:  pattern_chars_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Start of text restarts the search before the byte is applied.
  assign base_row0  = in_data.first_of_text ? ROW_W'(1) : row0_r;
  assign base_row1  = in_data.first_of_text ? ROW_W'(1) : row1_r;
  assign base_found = in_data.first_of_text ? 1'b0 : found_r;

  // An empty pattern or one led by a zero character never matches.
  assign pat_ok  = (pattern_length_r != '0) && (pattern_chars_r[CHAR_W-1:0] != '0);
  assign one_err = (pattern_length_r >= ERR_DIVISOR);

  // Compare the byte with every active pattern character.
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      match_mask[i] = (LEN_W'(i) < pattern_length_r) && !in_data.text_char[7] &&
                      (pattern_chars_r[i*CHAR_W +: CHAR_W] == in_data.text_char[CHAR_W-1:0]);
    end
  end

  assign pm_row = ROW_W'(match_mask);
  assign hit0   = base_row0 & pm_row;
  assign hit1   = base_row1 & pm_row;

  // Exact row, then the one-error row with insert, delete and substitute terms.
  assign upd_row0 = (hit0 << 1) | ROW_W'(1);
  assign upd_row1 = base_row0 | (hit1 << 1) | ((upd_row0 | hit1) << 1) |
                    ((base_row0 | hit1) << 1) | ROW_W'(1);

  assign last_row = one_err ? upd_row1 : upd_row0;

  // Next search state; rows freeze once a match has been seen.
  always_comb begin
    row0_nxt  = base_row0;
    row1_nxt  = base_row1;
    found_nxt = base_found;
    if (pat_ok && !base_found) begin
      row0_nxt = upd_row0;
      if (one_err) begin
        row1_nxt = upd_row1;
      end
      found_nxt = last_row[pattern_length_r];
    end
    result_nxt.match_found = pat_ok && found_nxt;
    result_nxt.search_done = in_data.last_of_text;
  end

  // Search state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row0_r  <= ROW_W'(1);
      row1_r  <= ROW_W'(1);
      found_r <= 1'b0;
    end else if (in_fire) begin
      row0_r  <= row0_nxt;
      row1_r  <= row1_nxt;
      found_r <= found_nxt;
    end
  end

  // Output register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (in_fire) begin
      if (!out_valid_r || out_fire) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      if (skid_valid_r) begin
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload follows the same steering as the valid bits.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (!out_valid_r || out_fire) begin
        out_data_r <= result_nxt;
      end else begin
        skid_data_r <= result_nxt;
      end
    end else if (out_fire && skid_valid_r) begin
      out_data_r <= skid_data_r;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/bitap_checker.sv */
// ----------------------------------------------------------------------------
// Bitap matcher port checker
// Watches the top-level ports for ordering and buffering errors.
// ----------------------------------------------------------------------------
`default_nettype none

module bitap_checker
  import bitap_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_data_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_data_t out_data
);

  // A stalled result keeps its valid and payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Every transferred byte leaves a result waiting.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("result missing after input transfer");

  // Input is held off only while the result register is full.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  // With an empty buffer, the end-of-text mark comes straight through.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=>
      out_data.search_done == $past(in_data.last_of_text))
    else $error("end-of-text mark lost");

endmodule

bind bitap_fuzzy_text_matcher_top bitap_checker u_bitap_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

/* dv/bitap_fuzzy_text_matcher_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bitap fuzzy text matcher testbench
// Streams framed text bytes through the matcher under several pattern setups
// and random handshake stalls. Each result is checked against a predicted
// answer from a shift-or row model kept alongside the block.
// ----------------------------------------------------------------------------

module bitap_fuzzy_text_matcher_top_tb;
  import bitap_pkg::*;

  // Predicts the matcher's answers and checks the results that come back.
  class match_scoreboard;
    logic [LEN_W-1:0]   pat_len;
    logic [CHARS_W-1:0] pat_chars;
    logic [ROW_W-1:0]   rows [2];
    bit                 found;
    out_data_t          answers [$];
    int                 failures;

    function new();
      pat_len   = '0;
      pat_chars = '0;
      failures  = 0;
      clear_search();
    endfunction

    function void clear_search();
      rows[0] = ROW_W'(1);
      rows[1] = ROW_W'(1);
      found   = 1'b0;
    endfunction

    function int pending();
      return answers.size();
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    // Mirrors a register write on the configuration channel.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_PATTERN_LENGTH: pat_len = val[LEN_W-1:0];
        REG_PATTERN_CHARS:  pat_chars = val;
        default: ;
      endcase
    endfunction

    // Advances the error rows by one text byte and queues the answer.
    function void note_text(in_data_t t);
      int               m, k, d, i;
      logic [ROW_W-1:0] pm, hit, ins, del, sub, prev_old, prev_new;
      bit               active;
      out_data_t        answer;
      m = int'(pat_len);
      if (m > MAX_PATTERN) m = MAX_PATTERN;
      if (t.first_of_text) clear_search();
      active = (m != 0) && (pat_chars[CHAR_W-1:0] != '0);
      if (active && !found) begin
        k  = m / int'(ERR_DIVISOR);
        pm = '0;
        // Bytes with the top bit set match nothing.
        if (!t.text_char[7]) begin
          for (i = 0; i < m; i++) begin
            if (pat_chars[CHAR_W*i +: CHAR_W] == t.text_char[CHAR_W-1:0]) pm[i] = 1'b1;
          end
        end
        prev_old = '0;
        prev_new = '0;
        for (d = 0; d <= k; d++) begin
          hit      = rows[d] & pm;
          ins      = prev_old | (hit << 1);
          del      = (prev_new | hit) << 1;
          sub      = (prev_old | hit) << 1;
          prev_old = rows[d];
          rows[d]  = ins | del | sub | ROW_W'(1);
          prev_new = rows[d];
        end
        if (rows[k][m]) found = 1'b1;
      end
      answer.match_found = active ? found : 1'b0;
      answer.search_done = t.last_of_text;
      answers.push_back(answer);
    endfunction

    // Compares one transferred result with the oldest predicted answer.
    function void check_result(out_data_t got);
      out_data_t want;
      if (answers.size() == 0) begin
        flag($sformatf("unexpected result: match_found=%0b search_done=%0b",
                       got.match_found, got.search_done));
        return;
      end
      want = answers.pop_front();
      if (got.match_found !== want.match_found || got.search_done !== want.search_done)
        flag($sformatf("mismatch: expected match_found=%0b search_done=%0b, got %0b %0b",
                       want.match_found, want.search_done,
                       got.match_found, got.search_done));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_data_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_data_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  match_scoreboard    sb = new();
  int                 send_idle_pct;
  int                 recv_idle_pct;
  logic [LEN_W-1:0]   cur_len;
  logic [CHARS_W-1:0] cur_chars;

  bitap_fuzzy_text_matcher_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side stalls at random.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Every result transfer is checked.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // Offers one text byte, with random idle cycles first, and waits for the transfer.
  task automatic send_byte(logic [7:0] ch, logic first, logic last);
    in_data_t item;
    item.text_char     = ch;
    item.first_of_text = first;
    item.last_of_text  = last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_text(item);
  endtask

  // Holds the text side until every predicted answer has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_pattern(logic [LEN_W-1:0] len, logic [CHARS_W-1:0] chars);
    wait_idle();
    write_cfg(REG_PATTERN_LENGTH, CFG_DATA_W'(len));
    write_cfg(REG_PATTERN_CHARS, chars);
    cur_len   = len;
    cur_chars = chars;
  endtask

  // Pattern characters drawn mostly from a small alphabet so that texts can hit them.
  function automatic logic [CHARS_W-1:0] random_pattern_chars();
    logic [CHARS_W-1:0] v;
    int                 i, r;
    v = '0;
    if ($urandom_range(7) == 0) return CHARS_W'({$urandom, $urandom});
    for (i = 0; i < MAX_PATTERN; i++) begin
      r = $urandom_range(15);
      if (r == 0) v[CHAR_W*i +: CHAR_W] = '0;
      else if (r == 1) v[CHAR_W*i +: CHAR_W] = '1;
      else if (r < 4) v[CHAR_W*i +: CHAR_W] = CHAR_W'($urandom_range(127));
      else v[CHAR_W*i +: CHAR_W] = CHAR_W'(7'h61 + $urandom_range(3));
    end
    return v;
  endfunction

  // Picks a text byte: a copy of the pattern with rare edits, alphabet filler or noise.
  function automatic logic [7:0] text_byte(int mode, int pos);
    if (mode < 5 && pos >= 0 && pos < int'(cur_len) && $urandom_range(7) != 0)
      return {1'b0, cur_chars[CHAR_W*pos +: CHAR_W]};
    if (mode < 8 && $urandom_range(7) != 0) return 8'h61 + 8'($urandom_range(3));
    return 8'($urandom_range(255));
  endfunction

  // Sends one text; most are framed properly, some carry random framing flags.
  task automatic send_random_text(output int count);
    int   len, mode, start, j;
    logic first, last;
    len   = $urandom_range(1, 10);
    mode  = $urandom_range(9);
    start = $urandom_range(3);
    for (j = 0; j < len; j++) begin
      if (mode < 8) begin
        first = (j == 0);
        last  = (j == len - 1);
      end else begin
        first = ($urandom_range(3) == 0);
        last  = ($urandom_range(3) == 0);
      end
      send_byte(text_byte(mode, j - start), first, last);
    end
    count = len;
  endtask

  initial begin
    int phase, seg, sent, n;
    bit drained;
    send_idle_pct = 7;
    recv_idle_pct = 69;
    cur_len   = '0;
    cur_chars = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Pattern empty after reset: never a match.
    send_byte(8'h61, 1'b1, 1'b1);

    // Exact match of a short pattern.
    write_pattern(3'd3, {28'd0, 7'h63, 7'h62, 7'h61});
    send_byte(8'h61, 1'b1, 1'b0);
    send_byte(8'h62, 1'b0, 1'b0);
    send_byte(8'h63, 1'b0, 1'b1);
    // Bytes above 127 and byte zero.
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'h80, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);

    // Pattern whose first character is zero never matches.
    write_pattern(3'd3, {28'd0, 7'h63, 7'h62, 7'h00});
    send_byte(8'h62, 1'b1, 1'b0);
    send_byte(8'h63, 1'b0, 1'b1);

    // A zero character after the first one matches byte zero; then the flag holds.
    write_pattern(3'd3, {28'd0, 7'h79, 7'h00, 7'h78});
    send_byte(8'h78, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h79, 1'b0, 1'b0);
    send_byte(8'h71, 1'b0, 1'b0);
    send_byte(8'h71, 1'b0, 1'b1);

    // Longest pattern of all-ones characters, matched with one character missing.
    write_pattern(3'd7, '1);
    send_byte(8'h7F, 1'b1, 1'b0);
    repeat (4) send_byte(8'h7F, 1'b0, 1'b0);
    send_byte(8'h7F, 1'b0, 1'b1);

    // Pattern changed in the middle of a text: the rows carry over.
    write_pattern(3'd5, {14'd0, 7'h65, 7'h64, 7'h63, 7'h62, 7'h61});
    send_byte(8'h61, 1'b1, 1'b0);
    send_byte(8'h62, 1'b0, 1'b0);
    write_pattern(3'd5, {14'd0, 7'h65, 7'h64, 7'h78, 7'h62, 7'h61});
    send_byte(8'h78, 1'b0, 1'b0);
    send_byte(8'h64, 1'b0, 1'b1);

    // Random texts under three stall profiles and several pattern setups.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 7;  recv_idle_pct = 69; end
        1: begin send_idle_pct = 69; recv_idle_pct = 7;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (seg = 0; seg < 4; seg++) begin
        if (seg == 0) write_pattern(3'd7, random_pattern_chars());
        else if (seg == 3 && phase == 1) write_pattern(3'd0, random_pattern_chars());
        else write_pattern(LEN_W'($urandom_range(1, 7)), random_pattern_chars());
        sent    = 0;
        drained = 1'b0;
        while (sent < 41) begin
          send_random_text(n);
          sent += n;
          if (seg == 2 && !drained && sent >= 20) begin
            wait_idle();
            drained = 1'b1;
          end
        end
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("bitap_fuzzy_text_matcher_top_tb OK");
    end else begin
      $display("bitap_fuzzy_text_matcher_top_tb NOT OK");
    end
    $finish;
  end

  // Watchdog for a run that stops making progress.
  initial begin
    #2000000;
    $display("bitap_fuzzy_text_matcher_top_tb NOT OK");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/bitap_pkg.sv
hw/rtl/bitap_fuzzy_text_matcher_top.sv
hw/rtl/bitap_checker.sv
dv/bitap_fuzzy_text_matcher_top_tb.sv
